// ----- rtl/core/ilem_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ilem_pkg: shared types and constants of the Ising lattice energy block
// Lattice size, derived widths, action and register codes, and the command
// and status words that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package ilem_pkg;

   localparam int SIDE   = 64;
   localparam int SITES  = SIDE * SIDE;
   localparam int ADDR_W = (SIDE > 1) ? $clog2(SIDE) : 1;

   // Port field widths are fixed by the interface.
   localparam int ACTION_W  = 2;
   localparam int COORD_W   = 6;
   localparam int MAG_OUT_W = 14;
   localparam int ENERGY_W  = 30;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 16;

   // Accumulator and arithmetic widths follow from the lattice size.
   localparam int PC_W   = $clog2(SIDE + 1);
   localparam int POP_W  = $clog2(SITES + 1);
   localparam int DIS_W  = $clog2(2 * SITES + 1);
   localparam int MAG_W  = POP_W + 2;
   localparam int BOND_W = DIS_W + 2;
   localparam int JB_W   = CSR_W + BOND_W;
   localparam int BM_W   = CSR_W + MAG_W;
   localparam int ESUM_W = ((JB_W > BM_W) ? JB_W : BM_W) + 1;

   localparam logic [CSR_W-1:0] COUPLING_RESET = 16'h0100;
   localparam logic [CSR_W-1:0] FIELD_RESET    = 16'h0000;

   typedef enum logic [ACTION_W-1:0] {
      ACT_FLIP    = 2'd0,
      ACT_WRITE   = 2'd1,
      ACT_MEASURE = 2'd2,
      ACT_NONE    = 2'd3
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COUPLING = 2'd0,
      CSR_FIELD    = 2'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      SRC_ITEM  = 2'd0,
      SRC_COUNT = 2'd1,
      SRC_LAST  = 2'd2
   } rd_src_type;

   typedef struct packed {
      logic              latch_item;
      logic              rd_en;
      rd_src_type        rd_src;
      logic [ADDR_W-1:0] cnt;
      logic              wr_en;
      logic              clr_acc;
      logic              load_prev;
      logic              accum;
      logic              do_mul;
      logic              do_sum;
   } cmd_type;

   typedef struct packed {
      logic in_range;
   } status_type;

endpackage : ilem_pkg
`default_nettype wire

// ----- rtl/core/ilem_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ilem_ctrl: sequencer of the Ising lattice energy block
// Decodes each accepted word, steps the row counter of a lattice walk and
// drives the datapath commands and the result strobe.
// ----------------------------------------------------------------------------
module ilem_ctrl
   import ilem_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [ACTION_W-1:0] req_action,
   input  wire status_type          status,
   output      cmd_type             cmd,
   output      logic                busy,
   output      logic                rsp_valid
);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_RD    = 8'b0000_0010,
      S_WR    = 8'b0000_0100,
      S_PRIME = 8'b0000_1000,
      S_WALK  = 8'b0001_0000,
      S_LAST  = 8'b0010_0000,
      S_MUL   = 8'b0100_0000,
      S_SUM   = 8'b1000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = 1'b0;
      cmd          = '0;
      cmd.rd_src   = SRC_ITEM;
      cmd.cnt      = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            cmd.latch_item = start;
            if (start) begin
               case (action_type'(req_action))
                  ACT_FLIP, ACT_WRITE: begin
                     if (status.in_range) begin
                        state_in = S_RD;
                     end
                  end
                  ACT_MEASURE: state_in = S_PRIME;
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_WR;
         end
         S_WR: begin
            cmd.wr_en = 1'b1;
            state_in  = S_IDLE;
         end
         S_PRIME: begin
            // The last row is read first: it is the upper neighbor of row zero.
            cmd.rd_en   = 1'b1;
            cmd.rd_src  = SRC_LAST;
            cmd.clr_acc = 1'b1;
            cnt_in      = '0;
            state_in    = S_WALK;
         end
         S_WALK: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_src = SRC_COUNT;
            if (cnt_ff == '0) begin
               cmd.load_prev = 1'b1;
            end else begin
               cmd.accum = 1'b1;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == ADDR_W'(SIDE - 1)) begin
               state_in = S_LAST;
            end
         end
         S_LAST: begin
            cmd.accum = 1'b1;
            state_in  = S_MUL;
         end
         S_MUL: begin
            cmd.do_mul = 1'b1;
            state_in   = S_SUM;
         end
         S_SUM: begin
            cmd.do_sum   = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule : ilem_ctrl
`default_nettype wire

// ----- rtl/core/ilem_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ilem_dp: datapath of the Ising lattice energy block
// Holds the row-wide spin memory with per-row valid bits, the configuration
// registers, the row accumulators and the two-step energy arithmetic.
// ----------------------------------------------------------------------------
module ilem_dp
   import ilem_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cmd_type              cmd,
   output      status_type           status,
   input  wire logic [ACTION_W-1:0]  req_action,
   input  wire logic [COORD_W-1:0]   req_row,
   input  wire logic [COORD_W-1:0]   req_col,
   input  wire logic                 req_spin_value,
   input  wire logic                 csr_write,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata,
   output      logic [MAG_OUT_W-1:0] rsp_magnetization_total,
   output      logic [ENERGY_W-1:0]  rsp_energy_total
);

   function automatic logic [PC_W-1:0] popcount(input logic [SIDE-1:0] bits);
      logic [PC_W-1:0] sum;
      sum = '0;
      for (int i = 0; i < SIDE; i++) begin
         sum = sum + PC_W'(bits[i]);
      end
      return sum;
   endfunction

   // Spin memory: one word per row, bit 1 is spin +1. A row never written
   // reads as all +1 through its valid bit.
   logic [SIDE-1:0]   mem [SIDE];
   logic [SIDE-1:0]   row_valid_ff;
   logic [SIDE-1:0]   rd_data_ff;
   logic              rd_valid_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic [SIDE-1:0]   row_q;
   logic [SIDE-1:0]   row_new;
   logic [SIDE-1:0]   bit_mask;

   logic [COORD_W-1:0] row_ff, col_ff;
   logic               spin_ff, is_write_ff;
   logic [ADDR_W-1:0]  row_addr, col_addr;

   logic signed [CSR_W-1:0] coupling_ff, field_ff;

   logic [SIDE-1:0]  prev_ff;
   logic [SIDE-1:0]  row_rot;
   logic [POP_W-1:0] pop_ff;
   logic [DIS_W-1:0] dis_ff;
   logic [PC_W:0]    dis_row;

   logic signed [MAG_W-1:0]  mag;
   logic signed [BOND_W-1:0] bonds;
   logic signed [JB_W-1:0]   jb_ff;
   logic signed [BM_W-1:0]   bm_ff;
   logic signed [ESUM_W-1:0] energy;
   logic [MAG_OUT_W-1:0]     mag_out_ff;
   logic [ENERGY_W-1:0]      energy_out_ff;

   assign status.in_range = (int'(req_row) < SIDE) && (int'(req_col) < SIDE);

   always_ff @(posedge clock) begin
      if (cmd.latch_item) begin
         row_ff      <= req_row;
         col_ff      <= req_col;
         spin_ff     <= req_spin_value;
         is_write_ff <= (action_type'(req_action) == ACT_WRITE);
      end
   end

   assign row_addr = ADDR_W'(row_ff);
   assign col_addr = ADDR_W'(col_ff);

   always_comb begin
      case (cmd.rd_src)
         SRC_ITEM:  rd_addr = row_addr;
         SRC_COUNT: rd_addr = cmd.cnt;
         SRC_LAST:  rd_addr = ADDR_W'(SIDE - 1);
         default:   rd_addr = row_addr;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         rd_valid_ff <= row_valid_ff[rd_addr];
      end
      if (cmd.wr_en) begin
         mem[row_addr] <= row_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (cmd.wr_en) begin
         row_valid_ff[row_addr] <= 1'b1;
      end
   end

   assign row_q    = rd_valid_ff ? rd_data_ff : '1;
   assign bit_mask = SIDE'(1) << col_addr;

   always_comb begin
      if (!is_write_ff) begin
         row_new = row_q ^ bit_mask;
      end else if (spin_ff) begin
         row_new = row_q | bit_mask;
      end else begin
         row_new = row_q & ~bit_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coupling_ff <= COUPLING_RESET;
         field_ff    <= FIELD_RESET;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_COUPLING: coupling_ff <= csr_wdata;
            CSR_FIELD:    field_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Bit c of the rotated row is the right-hand neighbor of column c.
   // A bond contributes +1 when both ends agree and -1 otherwise, so only
   // the disagreements need counting: against the right and the upper row.
   assign row_rot = {row_q[0], row_q[SIDE-1:1]};
   assign dis_row = (PC_W + 1)'(popcount(row_q ^ row_rot)) +
                    (PC_W + 1)'(popcount(row_q ^ prev_ff));

   always_ff @(posedge clock) begin
      if (cmd.load_prev || cmd.accum) begin
         prev_ff <= row_q;
      end
      if (cmd.clr_acc) begin
         pop_ff <= '0;
         dis_ff <= '0;
      end else if (cmd.accum) begin
         pop_ff <= pop_ff + POP_W'(popcount(row_q));
         dis_ff <= dis_ff + DIS_W'(dis_row);
      end
   end

   // Spin sum is twice the count of up spins less the site count; the bond
   // sum is the bond count (twice the site count) less twice the disagreements.
   assign mag   = signed'(MAG_W'({pop_ff, 1'b0})) - signed'(MAG_W'(SITES));
   assign bonds = signed'(BOND_W'(2 * SITES)) - signed'(BOND_W'({dis_ff, 1'b0}));

   always_ff @(posedge clock) begin
      if (cmd.do_mul) begin
         jb_ff <= JB_W'(coupling_ff) * JB_W'(bonds);
         bm_ff <= BM_W'(field_ff) * BM_W'(mag);
      end
   end

   assign energy = ESUM_W'(bm_ff) - ESUM_W'(jb_ff);

   always_ff @(posedge clock) begin
      if (cmd.do_sum) begin
         mag_out_ff    <= MAG_OUT_W'(mag);
         energy_out_ff <= ENERGY_W'(energy);
      end
   end

   assign rsp_magnetization_total = mag_out_ff;
   assign rsp_energy_total        = energy_out_ff;

endmodule : ilem_dp
`default_nettype wire

// ----- rtl/core/ising_lattice_energy_magnetization_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ising_lattice_energy_magnetization_top: Ising lattice energy and spin sum
// A 64 x 64 torus of spins with flip, write and measure commands.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low. Flip and write
// read the addressed row of the spin memory and write it back, and busy stays
// high until the write is done. A measure walks the memory one row per cycle;
// the result strobe rsp_valid rises when the walk and the arithmetic are done,
// and busy falls in that same cycle, so the next word can be given while
// the result is shown. The strobe is high for exactly one cycle and cannot
// be stalled, and the rsp_ ports hold the totals until the next measure;
// the totals are not divided by the site count. Configuration writes are
// always taken (csr_ready is high) and belong in the time the block is idle.
// After reset all spins read as +1 at once; there is no clearing pass.
// ----------------------------------------------------------------------------
module ising_lattice_energy_magnetization_top
   import ilem_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output      logic                 busy,
   input  wire logic [ACTION_W-1:0]  req_action,
   input  wire logic [COORD_W-1:0]   req_row,
   input  wire logic [COORD_W-1:0]   req_col,
   input  wire logic                 req_spin_value,
   output      logic                 rsp_valid,
   output      logic [MAG_OUT_W-1:0] rsp_magnetization_total,
   output      logic [ENERGY_W-1:0]  rsp_energy_total,
   input  wire logic                 csr_valid,
   output      logic                 csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   ilem_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_valid  (rsp_valid)
   );

   ilem_dp u_dp (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .status                  (status),
      .req_action              (req_action),
      .req_row                 (req_row),
      .req_col                 (req_col),
      .req_spin_value          (req_spin_value),
      .csr_write               (csr_valid && csr_ready),
      .csr_index               (csr_index),
      .csr_wdata               (csr_wdata),
      .rsp_magnetization_total (rsp_magnetization_total),
      .rsp_energy_total        (rsp_energy_total)
   );

   // A result is a single-cycle pulse.
   a_rsp_pulse : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // A measure keeps the block busy while the lattice is walked.
   a_measure_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_action == ACT_MEASURE) |=> (busy && !rsp_valid))
      else $error("measure did not occupy the block");

   // Flips and writes never produce a result.
   a_flip_silent : assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_action == ACT_FLIP || req_action == ACT_WRITE))
      |=> ##1 !rsp_valid)
      else $error("result strobe after a flip or write");

   // No result appears while no word is in progress.
   a_rsp_after_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without a measure in progress");

endmodule : ising_lattice_energy_magnetization_top
`default_nettype wire
